FILE: rtl/core/lqs_pkg.sv
package lqs_pkg;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_COUNT = 1'b1;

   localparam logic [7:0] QUANTUM_RESET    = 8'd4;
   localparam logic [7:0] QUANTUM_MIN      = 8'd1;
   localparam logic [4:0] PROC_COUNT_RESET = 5'd4;

   localparam int TICKET_W   = 6;
   localparam int TICKET_MAX = 50;
   localparam logic [3:0]          TICKET_BASE  = 4'd5;
   localparam logic [3:0]          TICKET_MIN   = 4'd1;
   localparam logic [TICKET_W-1:0] TICKET_SCALE = 6'd10;

   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [3:0]  prio;
      logic [15:0] remaining;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic load_wr;
      logic draw_start;
      logic scan;
      logic decide;
      logic mult;
      logic pick;
      logic fetch;
      logic update;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pick_done;
      logic no_work;
   } dp_stat_type;

   function automatic logic [TICKET_W-1:0] tickets_of(input logic [3:0] prio);
      logic [3:0] base;
      base = (prio < TICKET_BASE) ? (TICKET_BASE - prio) : 4'd0;
      if (base < TICKET_MIN) base = TICKET_MIN;
      return TICKET_W'(base) * TICKET_SCALE;
   endfunction

endpackage

FILE: rtl/core/lqs_ram.sv
module lqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lqs_dp.sv
module lqs_dp import lqs_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic [3:0]            req_entry_index,
   input  logic [15:0]           req_arrival,
   input  logic [15:0]           req_burst,
   input  logic [3:0]            req_priority_req,
   input  logic [15:0]           req_random_value,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   output logic [3:0]            rsp_winner,
   output logic [31:0]           rsp_slice_start,
   output logic [31:0]           rsp_slice_end,
   output logic                  rsp_finished,
   output logic [31:0]           rsp_turnaround,
   output logic [31:0]           rsp_waiting,
   output logic                  rsp_all_done
);

   localparam int AW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW    = $clog2(MAX_PROCS + 1);
   localparam int TOT_W = $clog2(TICKET_MAX * MAX_PROCS + 1);
   localparam int PW    = 16 + TOT_W;

   logic [7:0]           quantum_ff, quantum_in;
   logic [4:0]           pcount_ff, pcount_in;
   logic [31:0]          clock_ff, clock_in;
   logic [MAX_PROCS-1:0] valid_ff, valid_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pipe_v_ff, pipe_v_in;
   logic [AW-1:0]        pipe_idx_ff, pipe_idx_in;
   logic [15:0]          rand_ff, rand_in;
   logic                 any_ready_ff, any_ready_in;
   logic                 any_pend_ff, any_pend_in;
   logic [15:0]          earliest_ff, earliest_in;
   logic [TOT_W-1:0]     tot_ready_ff, tot_ready_in;
   logic [TOT_W-1:0]     tot_early_ff, tot_early_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [TOT_W-1:0]     target_ff, target_in;
   logic [TOT_W-1:0]     acc_ff, acc_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        win_ff, win_in;
   logic                 alldone_ff, alldone_in;
   logic [31:0]          start_ff, start_in;
   logic                 fin_ff, fin_in;
   logic [15:0]          arr_w_ff, arr_w_in;
   logic [16:0]          ab_sum_ff, ab_sum_in;

   logic [3:0]  rsp_winner_ff, rsp_winner_in;
   logic [31:0] rsp_start_ff, rsp_start_in;
   logic [31:0] rsp_end_ff, rsp_end_in;
   logic        rsp_fin_ff, rsp_fin_in;
   logic [31:0] rsp_ta_ff, rsp_ta_in;
   logic [31:0] rsp_wait_ff, rsp_wait_in;
   logic        rsp_done_ff, rsp_done_in;

   logic [CW-1:0]       used_n;
   logic [AW-1:0]       slot_addr;
   logic                load_ok;
   logic                issue;
   logic [AW-1:0]       ram_addr;
   logic                ram_we;
   entry_type           ram_wdata;
   entry_type           rd_entry;
   logic [15:0]         rd_rem;
   logic                rd_ready;
   logic [TICKET_W-1:0] tix;
   logic [TOT_W-1:0]    acc_next;
   logic [PW-1:0]       product;
   logic [7:0]          q_eff;
   logic [15:0]         run;
   logic [15:0]         rem_new;

   always_comb begin
      if (32'(pcount_ff) > 32'(MAX_PROCS)) begin
         used_n = CW'(MAX_PROCS);
      end else begin
         used_n = CW'(pcount_ff);
      end
   end

   assign slot_addr = AW'(req_entry_index);
   assign load_ok   = cmd.load_wr && (32'(req_entry_index) < 32'(MAX_PROCS));
   assign issue     = (cmd.scan || (cmd.pick && !found_ff)) && (cnt_ff < used_n);

   assign rd_rem   = valid_ff[pipe_idx_ff] ? rd_entry.remaining : 16'd0;
   assign rd_ready = (rd_rem != 16'd0) && (32'(rd_entry.arrival) <= clock_ff);
   assign tix      = tickets_of(rd_entry.prio);
   assign acc_next = acc_ff + TOT_W'(tix);
   assign product  = PW'(rand_ff) * PW'(total_ff);

   assign q_eff   = (quantum_ff == 8'd0) ? QUANTUM_MIN : quantum_ff;
   assign run     = (rd_rem < 16'(q_eff)) ? rd_rem : 16'(q_eff);
   assign rem_new = rd_rem - run;

   always_comb begin
      if (cmd.fetch || cmd.update) begin
         ram_addr = win_ff;
      end else if (cmd.load_wr) begin
         ram_addr = slot_addr;
      end else begin
         ram_addr = cnt_ff[AW-1:0];
      end
   end

   assign ram_we = load_ok || cmd.update;

   always_comb begin
      if (cmd.update) begin
         ram_wdata           = rd_entry;
         ram_wdata.remaining = rem_new;
      end else begin
         ram_wdata.arrival   = req_arrival;
         ram_wdata.burst     = req_burst;
         ram_wdata.prio      = req_priority_req;
         ram_wdata.remaining = req_burst;
      end
   end

   lqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PROCS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (rd_entry)
   );

   always_comb begin
      quantum_in   = quantum_ff;
      pcount_in    = pcount_ff;
      clock_in     = clock_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      pipe_v_in    = issue;
      pipe_idx_in  = ram_addr;
      rand_in      = rand_ff;
      any_ready_in = any_ready_ff;
      any_pend_in  = any_pend_ff;
      earliest_in  = earliest_ff;
      tot_ready_in = tot_ready_ff;
      tot_early_in = tot_early_ff;
      total_in     = total_ff;
      target_in    = target_ff;
      acc_in       = acc_ff;
      found_in     = found_ff;
      win_in       = win_ff;
      alldone_in   = alldone_ff;
      start_in     = start_ff;
      fin_in       = fin_ff;
      arr_w_in     = arr_w_ff;
      ab_sum_in    = ab_sum_ff;

      rsp_winner_in = rsp_winner_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_ta_in     = rsp_ta_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_done_in   = rsp_done_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_QUANTUM:    quantum_in = csr_wr_data;
            CSR_PROC_COUNT: pcount_in  = csr_wr_data[4:0];
            default: ;
         endcase
      end

      if (load_ok) begin
         valid_in[slot_addr] = 1'b1;
         clock_in            = 32'd0;
      end

      if (issue) begin
         cnt_in = cnt_ff + CW'(1);
      end

      if (cmd.draw_start) begin
         rand_in      = req_random_value;
         cnt_in       = '0;
         any_ready_in = 1'b0;
         any_pend_in  = 1'b0;
         tot_ready_in = '0;
         tot_early_in = '0;
         alldone_in   = 1'b0;
      end

      if (cmd.scan && pipe_v_ff && (rd_rem != 16'd0)) begin
         if (32'(rd_entry.arrival) <= clock_ff) begin
            any_ready_in = 1'b1;
            tot_ready_in = tot_ready_ff + TOT_W'(tix);
         end else if (!any_pend_ff || (rd_entry.arrival < earliest_ff)) begin
            any_pend_in  = 1'b1;
            earliest_in  = rd_entry.arrival;
            tot_early_in = TOT_W'(tix);
         end else if (rd_entry.arrival == earliest_ff) begin
            tot_early_in = tot_early_ff + TOT_W'(tix);
         end
      end

      if (cmd.decide) begin
         alldone_in = !any_ready_ff && !any_pend_ff;
         if (!any_ready_ff) begin
            if (any_pend_ff) begin
               clock_in = 32'(earliest_ff);
            end
            total_in = tot_early_ff;
         end else begin
            total_in = tot_ready_ff;
         end
      end

      if (cmd.mult) begin
         target_in = product[16 +: TOT_W];
         cnt_in    = '0;
         acc_in    = '0;
         found_in  = 1'b0;
         win_in    = '0;
      end

      if (cmd.pick && pipe_v_ff && !found_ff && rd_ready) begin
         acc_in = acc_next;
         if (target_ff < acc_next) begin
            found_in = 1'b1;
            win_in   = pipe_idx_ff;
         end
      end

      if (cmd.update) begin
         start_in  = clock_ff;
         clock_in  = clock_ff + 32'(run);
         fin_in    = (rem_new == 16'd0);
         arr_w_in  = rd_entry.arrival;
         ab_sum_in = 17'(rd_entry.arrival) + 17'(rd_entry.burst);
      end

      if (cmd.rsp_load) begin
         if (alldone_ff) begin
            rsp_winner_in = 4'd0;
            rsp_start_in  = 32'd0;
            rsp_end_in    = 32'd0;
            rsp_fin_in    = 1'b0;
            rsp_ta_in     = 32'd0;
            rsp_wait_in   = 32'd0;
            rsp_done_in   = 1'b1;
         end else begin
            rsp_winner_in = 4'(win_ff);
            rsp_start_in  = start_ff;
            rsp_end_in    = clock_ff;
            rsp_fin_in    = fin_ff;
            rsp_ta_in     = fin_ff ? (clock_ff - 32'(arr_w_ff)) : 32'd0;
            rsp_wait_in   = fin_ff ? (clock_ff - 32'(ab_sum_ff)) : 32'd0;
            rsp_done_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= QUANTUM_RESET;
         pcount_ff    <= PROC_COUNT_RESET;
         clock_ff     <= 32'd0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         pipe_v_ff    <= 1'b0;
         any_ready_ff <= 1'b0;
         any_pend_ff  <= 1'b0;
         found_ff     <= 1'b0;
         alldone_ff   <= 1'b0;
      end else begin
         quantum_ff   <= quantum_in;
         pcount_ff    <= pcount_in;
         clock_ff     <= clock_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         pipe_v_ff    <= pipe_v_in;
         any_ready_ff <= any_ready_in;
         any_pend_ff  <= any_pend_in;
         found_ff     <= found_in;
         alldone_ff   <= alldone_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff   <= pipe_idx_in;
      rand_ff       <= rand_in;
      earliest_ff   <= earliest_in;
      tot_ready_ff  <= tot_ready_in;
      tot_early_ff  <= tot_early_in;
      total_ff      <= total_in;
      target_ff     <= target_in;
      acc_ff        <= acc_in;
      win_ff        <= win_in;
      start_ff      <= start_in;
      fin_ff        <= fin_in;
      arr_w_ff      <= arr_w_in;
      ab_sum_ff     <= ab_sum_in;
      rsp_winner_ff <= rsp_winner_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_ta_ff     <= rsp_ta_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign stat.scan_done = (cnt_ff == used_n) && !pipe_v_ff;
   assign stat.pick_done = found_ff || ((cnt_ff == used_n) && !pipe_v_ff);
   assign stat.no_work   = !any_ready_ff && !any_pend_ff;

   assign rsp_winner      = rsp_winner_ff;
   assign rsp_slice_start = rsp_start_ff;
   assign rsp_slice_end   = rsp_end_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_turnaround  = rsp_ta_ff;
   assign rsp_waiting     = rsp_wait_ff;
   assign rsp_all_done    = rsp_done_ff;

`ifndef ASSERT_OFF
   a_found_past_target: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (target_ff < acc_ff))
      else $error("winner flagged without ticket sum passing target");

   a_found_from_pick: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |-> $past(pipe_v_ff && cmd.pick))
      else $error("winner flagged outside a pick beat");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      pipe_v_ff |-> (32'(pipe_idx_ff) < 32'(used_n)))
      else $error("table walk read past entries in use");
`endif

endmodule

FILE: rtl/core/lqs_ctrl.sv
module lqs_ctrl import lqs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_kind,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SCAN   = 8'b0000_0010,
      S_DECIDE = 8'b0000_0100,
      S_MULT   = 8'b0000_1000,
      S_PICK   = 8'b0001_0000,
      S_FETCH  = 8'b0010_0000,
      S_UPDATE = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd            = '0;
      cmd.load_wr    = accept && (req_kind == KIND_LOAD);
      cmd.draw_start = accept && (req_kind == KIND_DRAW);
      cmd.scan       = (state_ff == S_SCAN);
      cmd.decide     = (state_ff == S_DECIDE);
      cmd.mult       = (state_ff == S_MULT);
      cmd.pick       = (state_ff == S_PICK);
      cmd.fetch      = (state_ff == S_FETCH);
      cmd.update     = (state_ff == S_UPDATE);
      cmd.rsp_load   = (state_ff == S_OUT) && rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.draw_start) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = stat.no_work ? S_OUT : S_MULT;
         end
         S_MULT:   state_in = S_PICK;
         S_PICK: begin
            if (stat.pick_done) state_in = S_FETCH;
         end
         S_FETCH:  state_in = S_UPDATE;
         S_UPDATE: state_in = S_OUT;
         S_OUT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_draw_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_kind == KIND_DRAW)) |=> (state_ff == S_SCAN))
      else $error("accepted draw did not start the table scan");

   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("result beat not presented after load");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result beat raised outside the output state");
`endif

endmodule

FILE: rtl/core/lottery_quantum_scheduler.sv
// Load item: the table entry is written at the edge that accepts it; loads run back to back.
// Draw item: a first walk over the single-port table sums the tickets of the entries in use,
// a second walk picks the winner, whose entry is then fetched and updated; with no work left
// there is no second walk. One item at a time: the next item is taken once the result beat is
// loaded, even while it waits; a stalled beat delays the next one.
// Synchronous reset: all entries empty, clock zero, quantum 4, count 4.
module lottery_quantum_scheduler import lqs_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [3:0]            req_entry_index,
   input  logic [15:0]           req_arrival,
   input  logic [15:0]           req_burst,
   input  logic [3:0]            req_priority_req,
   input  logic [15:0]           req_random_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_winner,
   output logic [31:0]           rsp_slice_start,
   output logic [31:0]           rsp_slice_end,
   output logic                  rsp_finished,
   output logic [31:0]           rsp_turnaround,
   output logic [31:0]           rsp_waiting,
   output logic                  rsp_all_done
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   lqs_dp #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_entry_index  (req_entry_index),
      .req_arrival      (req_arrival),
      .req_burst        (req_burst),
      .req_priority_req (req_priority_req),
      .req_random_value (req_random_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_winner       (rsp_winner),
      .rsp_slice_start  (rsp_slice_start),
      .rsp_slice_end    (rsp_slice_end),
      .rsp_finished     (rsp_finished),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting),
      .rsp_all_done     (rsp_all_done)
   );

endmodule

FILE: tb/sv/tb_lottery_quantum_scheduler.sv
`timescale 1ns / 1ps

module tb_lottery_quantum_scheduler;
   import lqs_pkg::*;

   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAW_CAP      = 60;
   localparam int SLOTS         = 16;

   typedef struct packed {
      logic [3:0]  winner;
      logic [31:0] slice_start;
      logic [31:0] slice_end;
      logic        finished;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic        all_done;
   } slice_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_QUANTUM;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_LOAD;
   logic [3:0]            req_entry_index = '0;
   logic [15:0]           req_arrival = '0;
   logic [15:0]           req_burst = '0;
   logic [3:0]            req_priority_req = '0;
   logic [15:0]           req_random_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [3:0]            rsp_winner;
   logic [31:0]           rsp_slice_start;
   logic [31:0]           rsp_slice_end;
   logic                  rsp_finished;
   logic [31:0]           rsp_turnaround;
   logic [31:0]           rsp_waiting;
   logic                  rsp_all_done;

   // shadow of the process table and scheduler clock
   logic [15:0] tbl_arr [SLOTS];
   logic [15:0] tbl_bst [SLOTS];
   logic [3:0]  tbl_pri [SLOTS];
   logic [15:0] tbl_rem [SLOTS];
   logic [31:0] now_tick = '0;
   logic [7:0]  qtm_cfg = QUANTUM_RESET;
   logic [4:0]  cnt_cfg = PROC_COUNT_RESET;

   slice_type slice_q[$];

   int  send_idle_pct = 11;
   int  recv_idle_pct = 66;
   int  quiet_cycles = 0;
   int  mismatches = 0;
   int  items_sent = 0;
   int  loads_sent = 0;
   int  draws_sent = 0;
   int  slices_seen = 0;
   int  completions_seen = 0;
   int  empty_seen = 0;
   logic hold_on = 1'b0;
   event hold_start;

   lottery_quantum_scheduler i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_arrival      (req_arrival),
      .req_burst        (req_burst),
      .req_priority_req (req_priority_req),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_winner       (rsp_winner),
      .rsp_slice_start  (rsp_slice_start),
      .rsp_slice_end    (rsp_slice_end),
      .rsp_finished     (rsp_finished),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting),
      .rsp_all_done     (rsp_all_done)
   );

   always #5 clock = ~clock;

   initial begin
      for (int k = 0; k < SLOTS; k++) begin
         tbl_arr[k] = '0;
         tbl_bst[k] = '0;
         tbl_pri[k] = '0;
         tbl_rem[k] = '0;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] ticket_share(input logic [3:0] pri);
      if (pri < 4'd4) return 32'((5 - pri) * 10);
      return 32'd10;
   endfunction

   function automatic logic is_runnable(input int k);
      return tbl_rem[k] != 16'd0 && 32'(tbl_arr[k]) <= now_tick;
   endfunction

   function automatic void store_entry(input logic [3:0] slot, input logic [15:0] arr,
                                       input logic [15:0] bst, input logic [3:0] pri);
      tbl_arr[slot] = arr;
      tbl_bst[slot] = bst;
      tbl_pri[slot] = pri;
      tbl_rem[slot] = bst;
      now_tick = '0;
   endfunction

   function automatic slice_type run_lottery(input logic [15:0] rnd);
      slice_type   res;
      int          n, k, win;
      logic        any_ready, any_pending, found;
      logic [15:0] earliest, q, run;
      logic [31:0] total, target, acc;
      logic [47:0] prod;
      res = '0;
      n = (cnt_cfg > 5'd16) ? SLOTS : int'(cnt_cfg);
      any_ready = 1'b0;
      any_pending = 1'b0;
      earliest = '0;
      for (k = 0; k < n; k++) begin
         if (tbl_rem[k] != 16'd0) begin
            if (32'(tbl_arr[k]) <= now_tick) begin
               any_ready = 1'b1;
            end else if (!any_pending || tbl_arr[k] < earliest) begin
               earliest = tbl_arr[k];
               any_pending = 1'b1;
            end
         end
      end
      if (!any_ready) begin
         if (!any_pending) begin
            res.all_done = 1'b1;
            return res;
         end
         now_tick = 32'(earliest);
      end
      total = '0;
      for (k = 0; k < n; k++)
         if (is_runnable(k)) total += ticket_share(tbl_pri[k]);
      prod = 48'(rnd) * 48'(total);
      target = prod[47:16];
      win = 0;
      acc = '0;
      found = 1'b0;
      for (k = 0; k < n; k++) begin
         if (!found && is_runnable(k)) begin
            acc += ticket_share(tbl_pri[k]);
            if (target < acc) begin
               win = k;
               found = 1'b1;
            end
         end
      end
      q = (qtm_cfg == 8'd0) ? 16'd1 : 16'(qtm_cfg);
      run = (tbl_rem[win] < q) ? tbl_rem[win] : q;
      res.winner = 4'(win);
      res.slice_start = now_tick;
      tbl_rem[win] -= run;
      now_tick += 32'(run);
      res.slice_end = now_tick;
      if (tbl_rem[win] == 16'd0) begin
         res.finished = 1'b1;
         res.turnaround = now_tick - 32'(tbl_arr[win]);
         res.waiting = res.turnaround - 32'(tbl_bst[win]);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- result side

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      slice_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         slices_seen++;
         if (slice_q.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing expected, expected none, actual winner %0d",
                     $time, rsp_winner);
         end else begin
            want = slice_q.pop_front();
            check_field("winner", 32'(want.winner), 32'(rsp_winner));
            check_field("slice_start", want.slice_start, rsp_slice_start);
            check_field("slice_end", want.slice_end, rsp_slice_end);
            check_field("finished", 32'(want.finished), 32'(rsp_finished));
            check_field("turnaround", want.turnaround, rsp_turnaround);
            check_field("waiting", want.waiting, rsp_waiting);
            check_field("all_done", 32'(want.all_done), 32'(rsp_all_done));
            if (want.finished) completions_seen++;
            if (want.all_done) empty_seen++;
         end
      end
      if (hold_on) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // hold the result side off for a long stretch
   always begin
      @(hold_start);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_beat(input logic kind, input logic [3:0] slot, input logic [15:0] arr,
                            input logic [15:0] bst, input logic [3:0] pri,
                            input logic [15:0] rnd, output logic no_work);
      int        gap;
      slice_type want;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_entry_index  <= slot;
      req_arrival      <= arr;
      req_burst        <= bst;
      req_priority_req <= pri;
      req_random_value <= rnd;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      no_work = 1'b0;
      if (kind == KIND_LOAD) begin
         loads_sent++;
         store_entry(slot, arr, bst, pri);
      end else begin
         draws_sent++;
         want = run_lottery(rnd);
         slice_q.insert(slice_q.size(), want);
         no_work = want.all_done;
      end
   endtask

   task automatic drain_idle();
      req_valid <= 1'b0;
      while (slice_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input logic [7:0] qtm, input logic [4:0] cnt);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_QUANTUM;
      csr_wr_data <= qtm;
      @(posedge clock);
      qtm_cfg = qtm;
      csr_index   <= CSR_PROC_COUNT;
      csr_wr_data <= CSR_DATA_W'(cnt);
      @(posedge clock);
      cnt_cfg = cnt;
      csr_wr_en <= 1'b0;
   endtask

   task automatic load(input logic [3:0] slot, input logic [15:0] arr,
                       input logic [15:0] bst, input logic [3:0] pri);
      logic unused;
      send_beat(KIND_LOAD, slot, arr, bst, pri, 16'($urandom), unused);
   endtask

   task automatic draw(input logic [15:0] rnd, output logic no_work);
      send_beat(KIND_DRAW, 4'($urandom), 16'($urandom), 16'($urandom), 4'($urandom), rnd,
                no_work);
   endtask

   function automatic logic [15:0] pick_burst();
      case ($urandom_range(19))
         0:       return 16'($urandom_range(1, 65535));
         1:       return 16'd0;
         default: return 16'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic logic [15:0] pick_random();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_empty_table();
      logic fin;
      draw(16'h1234, fin);
      drain_idle();
   endtask

   task automatic test_field_extremes();
      logic fin;
      set_regs(8'd255, 5'd2);
      load(4'd0, 16'd0, 16'hFFFF, 4'd0);
      load(4'd1, 16'hFFFF, 16'd1, 4'd15);
      draw(16'hFFFF, fin);
      drain_idle();
   endtask

   task automatic test_clock_jump();
      logic fin;
      set_regs(8'd4, 5'd3);
      load(4'd0, 16'd100, 16'd3, 4'd5);
      load(4'd1, 16'd200, 16'd2, 4'd9);
      load(4'd2, 16'd300, 16'd0, 4'd2);
      repeat (4) draw(pick_random(), fin);
      drain_idle();
   endtask

   task automatic test_zero_quantum();
      logic fin;
      set_regs(8'd0, 5'd1);
      load(4'd0, 16'd0, 16'd2, 4'd3);
      repeat (3) draw(16'($urandom), fin);
      drain_idle();
   endtask

   task automatic test_count_limits();
      logic fin;
      set_regs(8'd1, 5'd0);
      draw(16'h8000, fin);
      drain_idle();
      set_regs(8'd7, 5'd31);
      load(4'd15, 16'd5, 16'd9, 4'd4);
      load(4'd3, 16'd0, 16'd3, 4'd1);
      draw(16'h0001, fin);
      draw(16'hFFFE, fin);
      drain_idle();
   endtask

   task automatic test_short_turnaround();
      logic fin;
      set_regs(8'd4, 5'd2);
      load(4'd0, 16'd0, 16'd10, 4'd0);
      draw(16'd0, fin);
      // reload clears the clock while slot 0 is partly done
      load(4'd1, 16'd0, 16'd1, 4'd15);
      draw(16'd0, fin);
      draw(16'hFFFF, fin);
      draw(16'd0, fin);
      draw(16'd0, fin);
      drain_idle();
   endtask

   task automatic run_workload();
      int   n, i, nxt, draws;
      logic fin;
      n = (cnt_cfg == 5'd0) ? $urandom_range(1, 4) : ((cnt_cfg > 5'd16) ? SLOTS : int'(cnt_cfg));
      if ($urandom_range(3) == 0) n = $urandom_range(1, n);
      nxt = ($urandom_range(7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
      for (i = 0; i < n; i++) begin
         load(4'(i), 16'(nxt), pick_burst(), 4'($urandom));
         nxt = nxt + $urandom_range(0, 30);
         if (nxt > 65535) nxt = 65535;
      end
      draws = 0;
      fin = 1'b0;
      while (!fin && draws < DRAW_CAP) begin
         draw(pick_random(), fin);
         draws++;
      end
      if ($urandom_range(3) == 0) draw(pick_random(), fin);
   endtask

   task automatic run_noise();
      int   i;
      logic fin;
      for (i = 0; i < $urandom_range(6, 12); i++) begin
         send_beat(1'($urandom), 4'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
                   16'($urandom), fin);
      end
   endtask

   task automatic test_random_traffic(input int s_pct, input int r_pct, input int quota);
      int          stop;
      logic [7:0]  qtm;
      logic [4:0]  cnt;
      send_idle_pct = s_pct;
      recv_idle_pct <= r_pct;
      stop = items_sent + quota;
      while (items_sent < stop) begin
         if ($urandom_range(3) == 0) begin
            drain_idle();
            case ($urandom_range(5))
               0:       qtm = 8'd0;
               1:       qtm = 8'd1;
               2:       qtm = 8'd255;
               3, 4:    qtm = 8'($urandom_range(1, 8));
               default: qtm = 8'($urandom);
            endcase
            case ($urandom_range(11))
               0:       cnt = 5'd0;
               1:       cnt = 5'd31;
               2:       cnt = 5'd16;
               3:       cnt = 5'd1;
               default: cnt = 5'($urandom_range(2, 16));
            endcase
            set_regs(qtm, cnt);
         end
         if ($urandom_range(9) == 0) run_noise();
         else run_workload();
      end
      drain_idle();
   endtask

   task automatic test_backpressure();
      int   i;
      logic fin;
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      set_regs(8'd4, 5'd4);
      for (i = 0; i < 4; i++) load(4'(i), 16'(i * 3), 16'd200, 4'(i));
      -> hold_start;
      // keep offering draws while the result side is held off
      for (i = 0; i < 12; i++) draw(16'($urandom), fin);
      drain_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_field_extremes();
      test_clock_jump();
      test_zero_quantum();
      test_count_limits();
      test_short_turnaround();
      test_random_traffic(11, 66, 430);
      test_random_traffic(66, 11, 430);
      test_backpressure();
      test_random_traffic(0, 0, 440);
      drain_idle();
      $display("summary: %0d beats in (%0d loads, %0d draws), %0d results checked",
               items_sent, loads_sent, draws_sent, slices_seen);
      $display("summary: %0d completions, %0d draws with no work, %0d mismatches",
               completions_seen, empty_seen, mismatches);
      if (mismatches == 0 && slice_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/lqs_pkg.sv
rtl/core/lqs_ram.sv
rtl/core/lqs_dp.sv
rtl/core/lqs_ctrl.sv
rtl/core/lottery_quantum_scheduler.sv
tb/sv/tb_lottery_quantum_scheduler.sv
